// File: sv/lfc_pkg.sv
// Package for the log frame CRC-32 framer: constants, state type and CRC byte update.
package lfc_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [15:0] MAGIC_WORD = 16'hCAFE;

    localparam int unsigned IDX_W    = 3;
    localparam logic [IDX_W-1:0] HDR_LAST  = 3'd5;
    localparam logic [IDX_W-1:0] TRL_LAST  = 3'd3;
    localparam logic [IDX_W-1:0] HDR_FEED0 = 3'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_PAY,
        ST_TRL
    } state_t;

    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: sv/lfc_in_if.sv
// Input channel: start and payload items of the log framer.
interface lfc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  log_level;
    logic [7:0]  frame_length;
    logic [15:0] msg_id;
    logic [7:0]  data_byte;

    modport source (output valid, cmd, log_level, frame_length, msg_id, data_byte,
                    input ready);
    modport sink   (input valid, cmd, log_level, frame_length, msg_id, data_byte,
                    output ready);
endinterface

// File: sv/lfc_out_if.sv
// Output channel: one frame byte per beat with its marks.
interface lfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
    logic       seq_error;

    modport source (output valid, out_byte, frame_end, run_last, seq_error, input ready);
    modport sink   (input valid, out_byte, frame_end, run_last, seq_error, output ready);
endinterface

// File: sv/log_frame_crc32_framer.sv
// Log frame builder with CRC-32 trailer: top level.
// The block sends one frame byte per beat on stream, at most one beat per cycle.
// A start item gives six header beats (FE, CA, level, length, id low, id high),
// or ten when its length is zero, as the four CRC bytes follow at once. A payload
// item gives one beat, five when it is the last byte of its frame. The CRC is
// CRC-32 (reflected, init all ones), updated one byte per beat over level,
// length, id and payload, and sent inverted, low byte first, frame_end on the last.
// A payload item with no open frame gives one beat with seq_error set.
// The next item is taken in the cycle its predecessor's last beat enters the
// output register, so items follow back to back; throughput is set by the
// single output byte lane.
module log_frame_crc32_framer
    import lfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lfc_in_if.sink    entry,
    lfc_out_if.source stream
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic        cmd_reg;
    logic [7:0]  level_reg;
    logic [7:0]  len_reg;
    logic [15:0] id_reg;
    logic [7:0]  data_reg;

    logic [31:0] crc_reg, crc_next;
    logic        open_reg, open_next;
    logic [7:0]  left_reg, left_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic        out_last_reg;
    logic        out_err_reg;

    logic        load;
    logic        emit;
    logic        accept;
    logic [7:0]  beat_byte;
    logic        beat_end;
    logic        beat_last;
    logic        beat_err;
    logic        go_trailer;
    logic [31:0] crc_inv;

    assign load    = !out_valid_reg || stream.ready;
    assign emit    = (state_reg != ST_IDLE) && load;
    assign entry.ready = (state_reg == ST_IDLE) || (emit && beat_last);
    assign accept  = entry.valid && entry.ready;
    assign crc_inv = ~crc_reg;

    // beat contents and state updates
    always_comb
    begin
        beat_byte  = 8'd0;
        beat_end   = 1'b0;
        beat_last  = 1'b0;
        beat_err   = 1'b0;
        go_trailer = 1'b0;
        crc_next   = crc_reg;
        open_next  = open_reg;
        left_next  = left_reg;
        case (state_reg)
            ST_HDR:
            begin
                case (idx_reg)
                    3'd0:    beat_byte = MAGIC_WORD[7:0];
                    3'd1:    beat_byte = MAGIC_WORD[15:8];
                    3'd2:    beat_byte = level_reg;
                    3'd3:    beat_byte = len_reg;
                    3'd4:    beat_byte = id_reg[7:0];
                    default: beat_byte = id_reg[15:8];
                endcase
                if (idx_reg == '0)
                begin
                    crc_next = CRC_INIT;
                end
                else if (idx_reg >= HDR_FEED0)
                begin
                    crc_next = crc_feed(crc_reg, beat_byte);
                end
                if (idx_reg == HDR_LAST)
                begin
                    go_trailer = (len_reg == 8'd0);
                    beat_last  = !go_trailer;
                    open_next  = !go_trailer;
                    left_next  = len_reg;
                end
            end
            ST_PAY:
            begin
                if (!open_reg)
                begin
                    beat_err  = 1'b1;
                    beat_last = 1'b1;
                end
                else
                begin
                    beat_byte  = data_reg;
                    crc_next   = crc_feed(crc_reg, data_reg);
                    left_next  = left_reg - 8'd1;
                    go_trailer = (left_reg == 8'd1);
                    beat_last  = !go_trailer;
                end
            end
            ST_TRL:
            begin
                case (idx_reg[1:0])
                    2'd0:    beat_byte = crc_inv[7:0];
                    2'd1:    beat_byte = crc_inv[15:8];
                    2'd2:    beat_byte = crc_inv[23:16];
                    default: beat_byte = crc_inv[31:24];
                endcase
                if (idx_reg == TRL_LAST)
                begin
                    beat_end  = 1'b1;
                    beat_last = 1'b1;
                    open_next = 1'b0;
                    left_next = 8'd0;
                end
            end
            default:
            begin
                beat_byte = 8'd0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if (accept)
        begin
            state_next = entry.cmd ? ST_PAY : ST_HDR;
            idx_next   = '0;
        end
        else if (emit)
        begin
            if (go_trailer)
            begin
                state_next = ST_TRL;
                idx_next   = '0;
            end
            else if (beat_last)
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            open_reg      <= 1'b0;
            left_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                crc_reg  <= crc_next;
                open_reg <= open_next;
                left_reg <= left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= entry.cmd;
            level_reg <= entry.log_level;
            len_reg   <= entry.frame_length;
            id_reg    <= entry.msg_id;
            data_reg  <= entry.data_byte;
        end
        if (emit)
        begin
            out_byte_reg <= beat_byte;
            out_end_reg  <= beat_end;
            out_last_reg <= beat_last;
            out_err_reg  <= beat_err;
        end
    end

    assign stream.valid     = out_valid_reg;
    assign stream.out_byte  = out_byte_reg;
    assign stream.frame_end = out_end_reg;
    assign stream.run_last  = out_last_reg;
    assign stream.seq_error = out_err_reg;

    a_ready_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (entry.ready && state_reg != ST_IDLE) |-> (emit && beat_last))
        else $error("input taken before last beat of current item");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.frame_end) |-> stream.run_last)
        else $error("frame end without run last");

    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.seq_error) |-> (stream.run_last && stream.out_byte == 8'd0))
        else $error("bad sequence error beat");

    a_trl_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRL) |-> (idx_reg <= TRL_LAST))
        else $error("trailer index out of range");

    a_pay_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAY) |-> cmd_reg)
        else $error("payload state with start item");

endmodule
